>>> rtl/iprt_pkg.sv
// Package with the shared types and codes of the IPv4 route table.
package iprt_pkg;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_FIND       = 3'd1,
        OP_SET_STATUS = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_REMOVE_LNK = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVAL    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  flags;
        logic [2:0]  link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_MOVE,
        S_DONE
    } state_t;

endpackage

>>> rtl/iprt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module iprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ipv4_route_table_unit.sv
// Top level of the IPv4 longest-prefix route table.
//
// The table holds up to TABLE_DEPTH routes in one synchronous RAM, sorted by
// netmask with the longest mask first. An item is taken when start is high
// and busy is low; busy then stays high until the result strobe. An
// operation that walks the table reads one entry per cycle through the
// single read port. A remove walks the whole table, and an insert walks it
// too and then appends the last shifted entry. A find or status change
// stops at the first hit. An insert that fails its checks or meets a full
// table ends without a walk. The next item can be taken in the first idle
// cycle after the strobe. Insert and remove shift entries by one place
// during the same walk: remove writes entry i to i-1 as it comes out of
// the RAM, and insert holds entry i in a carry register and then writes it
// to i+1. Remove-by-link compacts the table in one pass: kept entries are
// copied down to a write pointer. Result fields are valid only while done
// is high, for exactly one cycle; the receiver cannot stall the block.
// There is no clearing pass after reset; the entry count starts at zero and
// the data of entries at or above it is never used.
module ipv4_route_table_unit
    import iprt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int LINK_COUNT  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] address,
    input  logic [31:0] mask,
    input  logic [31:0] gateway_addr,
    input  logic [1:0]  route_flags,
    input  logic [2:0]  link_id,
    input  logic        set_up,
    output logic        done,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] route_dest,
    output logic [31:0] route_mask,
    output logic [31:0] route_gateway,
    output logic [1:0]  route_flag_bits,
    output logic [2:0]  route_link
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    // Item registers.
    op_t         op_reg;
    logic [31:0] addr_reg, mask_reg, gw_reg;
    logic [1:0]  fl_reg;
    logic [2:0]  lk_reg;
    logic        up_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;      // read index of the walk
    logic [CW-1:0] wp_reg, wp_next;        // compaction write pointer
    logic          hit_reg, hit_next;      // remove: target already passed; insert: shifting has begun
    entry_t        hold_reg, hold_next;    // insert: entry carried forward
    logic          placed_reg, placed_next;

    logic [1:0]  st_reg, st_next;
    logic        found_reg, found_next;
    entry_t      res_reg, res_next;
    logic        done_reg;

    // RAM port.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    iprt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Argument checks for insert.
    logic [31:0] inv_mask;
    logic [31:0] host;
    logic        mask_ok, gw_ok, link_ok, ins_ok;
    assign inv_mask = ~mask_reg;
    assign mask_ok  = ((inv_mask & (inv_mask + 32'd1)) == 32'd0);
    assign host     = gw_reg & inv_mask;
    assign gw_ok    = !fl_reg[1] ||
                      (gw_reg != 32'd0 && host != 32'd0 && host != inv_mask);
    assign link_ok  = ({29'd0, lk_reg} < 32'(LINK_COUNT));
    assign ins_ok   = mask_ok && gw_ok && link_ok;

    entry_t new_entry;
    assign new_entry = '{dest: addr_reg, mask: mask_reg, gateway: gw_reg,
                         flags: fl_reg, link: lk_reg};

    // The entry read in S_MOVE is the one at idx_reg - 1 (read issued last cycle).
    logic [CW-1:0] cur;
    assign cur = idx_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_next == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            addr_reg <= address;
            mask_reg <= mask;
            gw_reg   <= gateway_addr;
            fl_reg   <= route_flags;
            lk_reg   <= link_id;
            up_reg   <= set_up;
        end
        idx_reg    <= idx_next;
        wp_reg     <= wp_next;
        hit_reg    <= hit_next;
        hold_reg   <= hold_next;
        placed_reg <= placed_next;
        st_reg     <= st_next;
        found_reg  <= found_next;
        res_reg    <= res_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CHECK;
            S_CHECK:
            begin
                if (op_reg == OP_INSERT && (!ins_ok || count_reg == CW'(TABLE_DEPTH)))
                    state_next = S_DONE;
                else if (op_reg > OP_REMOVE_LNK)
                    state_next = S_DONE;
                else if (count_reg == '0 && op_reg != OP_INSERT)
                    state_next = S_DONE;
                else
                    state_next = S_READ;
            end
            S_READ:  state_next = S_MOVE;
            S_MOVE:
            begin
                // An insert runs one step past the last entry to append.
                if (op_reg == OP_INSERT)
                begin
                    if (placed_next)
                        state_next = S_DONE;
                end
                else if (op_reg == OP_FIND && found_next)
                    state_next = S_DONE;
                else if (op_reg == OP_SET_STATUS && st_next == ST_OK)
                    state_next = S_DONE;
                else if (idx_reg >= count_reg)
                    state_next = S_DONE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        wp_next     = wp_reg;
        hit_next    = hit_reg;
        hold_next   = hold_reg;
        placed_next = placed_reg;
        st_next     = st_reg;
        found_next  = found_reg;
        res_next    = res_reg;
        we          = 1'b0;
        waddr       = wp_reg[AW-1:0];
        wdata       = rdata;
        raddr       = idx_reg[AW-1:0];
        case (state_reg)
            S_CHECK:
            begin
                idx_next    = '0;
                wp_next     = '0;
                hit_next    = 1'b0;
                hold_next   = new_entry;
                placed_next = 1'b0;
                found_next  = 1'b0;
                res_next    = '0;
                st_next     = ST_OK;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!ins_ok)
                            st_next = ST_INVAL;
                        else if (count_reg == CW'(TABLE_DEPTH))
                            st_next = ST_FULL;
                        else if (count_reg == '0)
                        begin
                            // Empty table: write directly.
                            we          = 1'b1;
                            waddr       = '0;
                            wdata       = new_entry;
                            count_next  = CW'(1);
                            placed_next = 1'b1;
                            idx_next    = CW'(TABLE_DEPTH) + CW'(1);
                        end
                    end
                    OP_FIND, OP_SET_STATUS, OP_REMOVE:
                        st_next = ST_NOTFOUND;
                    OP_REMOVE_LNK: st_next = ST_OK;
                    default: st_next = ST_INVAL;
                endcase
            end
            S_READ:
            begin
                // Read of entry 0 is under way; advance the index.
                raddr    = '0;
                idx_next = CW'(1);
            end
            S_MOVE:
            begin
                raddr    = idx_reg[AW-1:0];
                idx_next = idx_reg + CW'(1);
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!placed_reg && cur < count_reg)
                        begin
                            if (hold_reg.mask >= rdata.mask)
                            begin
                                // Place new entry here and carry this one on.
                                we          = 1'b1;
                                waddr       = cur[AW-1:0];
                                wdata       = hold_reg;
                                hold_next   = rdata;
                                placed_next = 1'b0;
                                hit_next    = 1'b1;
                            end
                            else if (hit_reg)
                            begin
                                we        = 1'b1;
                                waddr     = cur[AW-1:0];
                                wdata     = hold_reg;
                                hold_next = rdata;
                            end
                        end
                        else if (!placed_reg)
                        begin
                            // Past the end: append the carried entry.
                            we          = 1'b1;
                            waddr       = cur[AW-1:0];
                            wdata       = hold_reg;
                            placed_next = 1'b1;
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    OP_FIND:
                    begin
                        if (rdata.flags[0] &&
                            ((rdata.dest ^ addr_reg) & rdata.mask) == 32'd0)
                        begin
                            found_next = 1'b1;
                            res_next   = rdata;
                            st_next    = ST_OK;
                        end
                    end
                    OP_SET_STATUS:
                    begin
                        if (rdata.dest == addr_reg)
                        begin
                            we       = 1'b1;
                            waddr    = cur[AW-1:0];
                            wdata    = rdata;
                            wdata.flags[0] = up_reg;
                            st_next  = ST_OK;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            we    = 1'b1;
                            waddr = wp_reg[AW-1:0];
                            wp_next = wp_reg + CW'(1);
                        end
                        else if (rdata.dest == addr_reg)
                        begin
                            hit_next = 1'b1;
                            st_next  = ST_OK;
                        end
                        else
                            wp_next = wp_reg + CW'(1);
                        if (idx_reg >= count_reg && (hit_reg || rdata.dest == addr_reg))
                            count_next = count_reg - CW'(1);
                    end
                    OP_REMOVE_LNK:
                    begin
                        if (rdata.link != lk_reg)
                        begin
                            we      = 1'b1;
                            waddr   = wp_reg[AW-1:0];
                            wp_next = wp_reg + CW'(1);
                        end
                        if (idx_reg >= count_reg)
                            count_next = (rdata.link != lk_reg) ? wp_reg + CW'(1)
                                                                : wp_reg;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign done            = done_reg;
    assign status          = st_reg;
    assign found           = found_reg;
    assign route_dest      = res_reg.dest;
    assign route_mask      = res_reg.mask;
    assign route_gateway   = res_reg.gateway;
    assign route_flag_bits = res_reg.flags;
    assign route_link      = res_reg.link;

    // The entry count never exceeds the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count overflow");

    // A result strobe always ends a busy period.
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without item");

    // Found is only reported with an ok status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_OK))
        else $error("found with bad status");

    // The count only changes while an item is at work.
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(busy) && !busy) |-> $stable(count_reg))
        else $error("count changed while idle");

endmodule
